// File: rtl/rvm_pkg.sv
// rvm_pkg: shared types and constants for the resampling voice mixer
// holds field widths, operation codes and the item and result beat structs
// no dependencies
package rvm_pkg;

	// sizing
	localparam int VOICES            = 8;
	localparam int SAMPLES_PER_VOICE = 4096;
	localparam int SAMPLE_BITS       = 16;
	localparam int FRAC_BITS         = 16;
	localparam int GAIN_FRAC         = 14;

	localparam int VOICE_W  = $clog2(VOICES);
	localparam int INDEX_W  = $clog2(SAMPLES_PER_VOICE);
	localparam int MEM_AW   = VOICE_W + INDEX_W;
	localparam int LEN_W    = INDEX_W + 1;
	localparam int STEP_W   = 20;
	localparam int GAIN_W   = 16;
	localparam int PHASE_W  = LEN_W + FRAC_BITS - 1;
	localparam int COUNT_W  = 4;

	// operation codes
	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_SET   = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;

	// input beat
	typedef struct packed {
		logic [1:0]               operation;
		logic [2:0]               voice;
		logic [11:0]              address;
		logic signed [15:0]       sample_value;
		logic [12:0]              table_length;
		logic [19:0]              step;
		logic [15:0]              gain;
	} rvm_item_t;

	// result beat
	typedef struct packed {
		logic signed [15:0] mixed_sample;
		logic               clipped;
	} rvm_result_t;

	// one voice parameter entry
	typedef struct packed {
		logic [LEN_W-1:0]   length;
		logic [STEP_W-1:0]  step;
		logic [GAIN_W-1:0]  gain;
		logic [PHASE_W-1:0] phase;
	} rvm_voice_t;

endpackage

// File: rtl/resampling_voice_mixer_core.sv
// resampling_voice_mixer_core: multi-voice looping sample playback mixer
// sample memory, voice parameter memory and the per-voice tick sequencer
// depends on rvm_pkg
//
// Usage: item beats carry one operation each. A write stores one sample word
// in the addressed voice table, a set-voice loads length, step and gain and
// clears the phase; neither gives a result. A tick walks the
// active voices one after another through the voice parameter memory and the
// two-port sample memory and gives one result beat.
// Tick sequence: a zero-length voice passes only the voice read and add; a
// playing voice goes through read, add, five compare-subtract steps of the
// phase wrap, sample reads, interpolation multiply and add, and gain
// multiply-accumulate. The sum is then rounded and the result registered.
// item_stall is high while a tick is in progress and while a voice count write
// is offered. A finished result sits in the output register; writes and
// set-voice beats are still taken while it waits, and a following tick runs
// but holds its result until the receiver takes the earlier one. cfg_ready is
// high only while idle.
// Reset clears the voice parameters (valid bits), sets voice_count to 8 and
// empties the output register. Sample words read before being written are
// undefined.
module resampling_voice_mixer_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  rvm_pkg::rvm_item_t    item,
	output logic                  result_valid,
	input  logic                  result_stall,
	output rvm_pkg::rvm_result_t  result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [3:0]            cfg_data
);
	import rvm_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_VRD  = 4'd1;
	localparam logic [3:0] ST_VADD = 4'd2;
	localparam logic [3:0] ST_MOD  = 4'd3;
	localparam logic [3:0] ST_WB   = 4'd4;
	localparam logic [3:0] ST_INT  = 4'd5;
	localparam logic [3:0] ST_ACC  = 4'd6;
	localparam logic [3:0] ST_MUL  = 4'd7;
	localparam logic [3:0] ST_DONE = 4'd8;

	localparam int SPAN_W = PHASE_W + 6;
	localparam int SUM_W  = SAMPLE_BITS + GAIN_W + VOICE_W + 2;
	localparam int PROD_W = 2 * (SAMPLE_BITS + 1);
	localparam int INT_W  = SAMPLE_BITS + 2;
	localparam int RND_W  = SUM_W - GAIN_FRAC;

	// memories
	logic signed [SAMPLE_BITS-1:0] smem [VOICES*SAMPLES_PER_VOICE];
	rvm_voice_t                    vmem [VOICES];
	logic [VOICES-1:0]             vvalid_q;

	logic [3:0]               state_q;
	logic [COUNT_W-1:0]       vcount_q;
	logic [VOICE_W-1:0]       vidx_q;
	logic [2:0]               mod_cnt_q;
	logic [PHASE_W:0]         x_q;
	rvm_voice_t               vrd_q;
	logic                     vrd_valid_q;
	logic signed [SAMPLE_BITS-1:0] s0_q, s1_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [INT_W-1:0]  interp_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic                     result_valid_q;
	rvm_result_t              result_q;

	logic                     item_acc;
	logic                     idle;
	logic [COUNT_W-1:0]       active;
	logic                     last_voice;
	rvm_voice_t               vcur;
	logic [LEN_W-1:0]         set_len;
	logic [SPAN_W-1:0]        span_sh;
	logic [INDEX_W-1:0]       idx0;
	logic [INDEX_W-1:0]       idx1;
	logic [INDEX_W:0]         idx_inc;
	logic [FRAC_BITS-1:0]     frac;
	logic signed [SAMPLE_BITS:0] diff;
	logic signed [PROD_W-1:0] prod_rnd;
	logic signed [INT_W-1:0]  interp;
	logic signed [SUM_W-1:0]  contrib;
	logic signed [SUM_W-1:0]  sum_rnd;
	logic signed [RND_W-1:0]  mixed_full;
	logic                     out_free;
	logic                     sat_hi, sat_lo;

	assign idle       = (state_q == ST_IDLE);
	assign item_stall = !idle || cfg_valid;
	assign cfg_ready  = idle;
	assign item_acc   = item_valid && !item_stall;
	assign out_free   = !result_valid_q || !result_stall;

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// clamp voice count to the number of voices
	assign active = (vcount_q > COUNT_W'(VOICES)) ? COUNT_W'(VOICES) : vcount_q;
	assign last_voice = (COUNT_W'(vidx_q) + COUNT_W'(1)) == active;

	// invalid entries read as zero
	assign vcur = vrd_valid_q ? vrd_q : '0;

	// saturate table length
	assign set_len = (item.table_length > LEN_W'(SAMPLES_PER_VOICE)) ?
		LEN_W'(SAMPLES_PER_VOICE) : item.table_length;

	// phase wrap: span shifted by the current step
	assign span_sh = {{(SPAN_W-LEN_W-FRAC_BITS){1'b0}}, vcur.length, {FRAC_BITS{1'b0}}}
		<< mod_cnt_q;

	// read indices and fraction from the wrapped phase
	assign idx0    = x_q[FRAC_BITS +: INDEX_W];
	assign idx_inc = {1'b0, idx0} + (INDEX_W+1)'(1);
	assign idx1    = (idx_inc == vcur.length) ? '0 : idx_inc[INDEX_W-1:0];
	assign frac    = x_q[FRAC_BITS-1:0];

	// interpolation arithmetic
	assign diff     = {s1_q[SAMPLE_BITS-1], s1_q} - {s0_q[SAMPLE_BITS-1], s0_q};
	assign prod_rnd = prod_q + PROD_W'(1 << (FRAC_BITS-1));
	assign interp   = INT_W'(s0_q) + INT_W'(prod_rnd >>> FRAC_BITS);

	// scaled voice contribution at full accumulator width
	assign contrib = interp_q * $signed({1'b0, vcur.gain});

	// final rounding and saturation
	assign sum_rnd    = sum_q + SUM_W'(1 << (GAIN_FRAC-1));
	assign mixed_full = RND_W'(sum_rnd >>> GAIN_FRAC);
	assign sat_hi     = mixed_full > RND_W'((1 << (SAMPLE_BITS-1)) - 1);
	assign sat_lo     = mixed_full < -RND_W'(1 << (SAMPLE_BITS-1));

	// sample memory: write on accepted write beat, two reads issued in writeback
	always_ff @(posedge clk) begin
		if (item_acc && item.operation == OP_WRITE && 32'(item.voice) < VOICES &&
			32'(item.address) < SAMPLES_PER_VOICE) begin
			smem[{VOICE_W'(item.voice), INDEX_W'(item.address)}] <= item.sample_value;
		end
		if (state_q == ST_WB) begin
			s0_q <= smem[{vidx_q, idx0}];
			s1_q <= smem[{vidx_q, idx1}];
		end
	end

	// voice parameter memory: set-voice or phase writeback, read in voice read
	always_ff @(posedge clk) begin
		if (item_acc && item.operation == OP_SET && 32'(item.voice) < VOICES) begin
			vmem[VOICE_W'(item.voice)] <= '{length: set_len, step: item.step,
				gain: item.gain, phase: '0};
		end else if (state_q == ST_WB) begin
			vmem[vidx_q] <= '{length: vcur.length, step: vcur.step,
				gain: vcur.gain, phase: x_q[PHASE_W-1:0]};
		end
		if (state_q == ST_VRD) begin
			vrd_q <= vmem[vidx_q];
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_VADD: begin
				x_q <= {1'b0, vcur.phase} + (PHASE_W+1)'(vcur.step);
			end
			ST_MOD: begin
				if (SPAN_W'(x_q) >= span_sh) begin
					x_q <= x_q - span_sh[PHASE_W:0];
				end
			end
			ST_INT: begin
				prod_q <= diff * $signed({1'b0, frac});
			end
			ST_ACC: begin
				interp_q <= interp;
			end
			default: begin
			end
		endcase
	end

	// control: sequencer, valid bits, config, accumulator, output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			vcount_q       <= COUNT_W'(VOICES);
			vidx_q         <= '0;
			mod_cnt_q      <= '0;
			vvalid_q       <= '0;
			vrd_valid_q    <= 1'b0;
			sum_q          <= '0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			// output beat: load a finished result or drop a taken one
			if (state_q == ST_DONE && out_free) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				vcount_q <= cfg_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (item_acc) begin
						if (item.operation == OP_SET && 32'(item.voice) < VOICES) begin
							vvalid_q[VOICE_W'(item.voice)] <= 1'b1;
						end
						if (item.operation == OP_TICK) begin
							sum_q  <= '0;
							vidx_q <= '0;
							state_q <= (active == '0) ? ST_DONE : ST_VRD;
						end
					end
				end
				ST_VRD: begin
					vrd_valid_q <= vvalid_q[vidx_q];
					state_q     <= ST_VADD;
				end
				ST_VADD: begin
					mod_cnt_q <= 3'd4;
					if (vcur.length == '0) begin
						if (last_voice) begin
							state_q <= ST_DONE;
						end else begin
							vidx_q  <= vidx_q + VOICE_W'(1);
							state_q <= ST_VRD;
						end
					end else begin
						state_q <= ST_MOD;
					end
				end
				ST_MOD: begin
					mod_cnt_q <= mod_cnt_q - 3'd1;
					if (mod_cnt_q == '0) begin
						state_q <= ST_WB;
					end
				end
				ST_WB: begin
					state_q <= ST_INT;
				end
				ST_INT: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					sum_q <= sum_q + contrib;
					if (last_voice) begin
						state_q <= ST_DONE;
					end else begin
						vidx_q  <= vidx_q + VOICE_W'(1);
						state_q <= ST_VRD;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						if (sat_hi) begin
							result_q <= '{mixed_sample: SAMPLE_BITS'((1 << (SAMPLE_BITS-1)) - 1),
								clipped: 1'b1};
						end else if (sat_lo) begin
							result_q <= '{mixed_sample: SAMPLE_BITS'(1 << (SAMPLE_BITS-1)),
								clipped: 1'b1};
						end else begin
							result_q <= '{mixed_sample: mixed_full[SAMPLE_BITS-1:0],
								clipped: 1'b0};
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
